FILE: src/pdftok_pkg.sv
// ----------------------------------------------------------------------------
// pdftok_pkg
// Shared types, codes and character helpers for the content-stream tokenizer.
// ----------------------------------------------------------------------------
package pdftok_pkg;

    // token kinds
    localparam logic [3:0] KIND_NUMBER   = 4'd0;
    localparam logic [3:0] KIND_STRING   = 4'd1;
    localparam logic [3:0] KIND_NAME     = 4'd2;
    localparam logic [3:0] KIND_ARR_OPEN = 4'd3;
    localparam logic [3:0] KIND_ARR_CLOSE = 4'd4;
    localparam logic [3:0] KIND_DICT_OPEN = 4'd5;
    localparam logic [3:0] KIND_DICT_CLOSE = 4'd6;
    localparam logic [3:0] KIND_OPERATOR = 4'd7;
    localparam logic [3:0] KIND_END      = 4'd8;

    // characters
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_LPAR   = 8'h28;
    localparam logic [7:0] CH_RPAR   = 8'h29;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_SEVEN  = 8'h37;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UF     = 8'h46;
    localparam logic [7:0] CH_LBRK   = 8'h5B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRK   = 8'h5D;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LB     = 8'h62;
    localparam logic [7:0] CH_LF_CH  = 8'h66;
    localparam logic [7:0] CH_LN     = 8'h6E;
    localparam logic [7:0] CH_LR     = 8'h72;
    localparam logic [7:0] CH_LT_CH  = 8'h74;
    localparam logic [7:0] CH_LBRC   = 8'h7B;
    localparam logic [7:0] CH_RBRC   = 8'h7D;

    localparam int GRP_SIZE = 4;

    // lexer modes
    typedef enum logic [3:0] {
        M_IDLE, M_COMMENT, M_OPER, M_NAME, M_HASH0, M_HASH1, M_NUM, M_LT, M_GT,
        M_STR, M_STR_ESC, M_STR_CR, M_STR_OCT, M_HEX
    } mode_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  token_kind;
        logic        has_byte;
        logic [7:0]  payload_byte;
        logic        token_done;
        logic [31:0] begin_offset;
        logic [31:0] end_offset;
        logic        number_negative;
        logic [47:0] number_mantissa;
        logic [3:0]  fraction_digits;
        logic        overflow_flag;
    } out_item_t;

    // results caused by one input transaction
    typedef struct packed {
        out_item_t [GRP_SIZE-1:0] item;
        logic [2:0]               cnt;
    } grp_t;

    function automatic logic is_ws(logic [7:0] c);
        return c == CH_NUL || c == CH_TAB || c == CH_LF || c == CH_FF ||
               c == CH_CR || c == CH_SPACE;
    endfunction

    function automatic logic is_delim(logic [7:0] c);
        return c == CH_LPAR || c == CH_RPAR || c == CH_LT || c == CH_GT ||
               c == CH_LBRK || c == CH_RBRK || c == CH_LBRC || c == CH_RBRC ||
               c == CH_SLASH || c == CH_PCT;
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic logic is_octal(logic [7:0] c);
        return c >= CH_ZERO && c <= CH_SEVEN;
    endfunction

    function automatic logic is_numch(logic [7:0] c);
        return is_digit(c) || c == CH_PLUS || c == CH_MINUS || c == CH_DOT;
    endfunction

    // hex digit value, bit 4 set when not a hex digit
    function automatic logic [4:0] hexval(logic [7:0] c);
        logic [7:0] v;
        v = 8'h10;
        if (is_digit(c))
            v = c - CH_ZERO;
        else if (c >= CH_LA && c <= CH_LF_CH)
            v = c - CH_LA + 8'd10;
        else if (c >= CH_UA && c <= CH_UF)
            v = c - CH_UA + 8'd10;
        return v[4:0];
    endfunction

    function automatic out_item_t mk_byte(logic [3:0] kind, logic [7:0] b);
        out_item_t r;
        r = '0;
        r.token_kind   = kind;
        r.has_byte     = 1'b1;
        r.payload_byte = b;
        return r;
    endfunction

    function automatic out_item_t mk_done(logic [3:0] kind, logic [31:0] beg,
                                          logic [31:0] fin, logic neg,
                                          logic [47:0] mant, logic [3:0] frac,
                                          logic ovf);
        out_item_t r;
        r = '0;
        r.token_kind    = kind;
        r.token_done    = 1'b1;
        r.begin_offset  = beg;
        r.end_offset    = fin;
        r.overflow_flag = ovf;
        if (kind == KIND_NUMBER) begin
            r.number_negative = neg;
            r.number_mantissa = mant;
            r.fraction_digits = frac;
        end
        return r;
    endfunction

    // append a result, anything past the fourth is dropped
    function automatic grp_t push(grp_t g, out_item_t it);
        grp_t r;
        r = g;
        if (r.cnt < 3'(GRP_SIZE)) begin
            r.item[r.cnt[1:0]] = it;
            r.cnt = r.cnt + 3'd1;
        end
        return r;
    endfunction

endpackage

FILE: src/pdftok_lexer.sv
// ----------------------------------------------------------------------------
// pdftok_lexer
// Lexer state and the per-byte decision logic; builds the results of one byte.
// ----------------------------------------------------------------------------
module pdftok_lexer
    import pdftok_pkg::*;
#(
    parameter int POS_BITS   = 32,
    parameter int DEPTH_BITS = 16,
    parameter int MANT_BITS  = 48
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     take,
    input  in_item_t item,
    output grp_t     grp
);

    typedef struct packed {
        logic [1:0]           phase;
        logic                 neg;
        logic [MANT_BITS-1:0] mant;
        logic [3:0]           frac;
        logic                 ovf;
    } num_t;

    localparam logic [MANT_BITS-1:0] MANT_MAX   = {MANT_BITS{1'b1}};
    localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = {DEPTH_BITS{1'b1}};

    mode_t                mode_reg, mode_next;
    logic [POS_BITS-1:0]  pos_reg, pos_next;
    logic [POS_BITS-1:0]  start_reg, start_next;
    logic [DEPTH_BITS-1:0] depth_reg, depth_next;
    logic [7:0]           oct_val_reg, oct_val_next;
    logic [1:0]           oct_cnt_reg, oct_cnt_next;
    logic [4:0]           hex_nib_reg, hex_nib_next;
    logic [7:0]           esc_reg, esc_next;
    num_t                 num_reg, num_next;

    // one number character
    function automatic num_t num_step(num_t s, logic [7:0] c);
        num_t r;
        logic [1:0] ph;
        logic [MANT_BITS+3:0] w;
        r = s;
        ph = s.phase;
        w = '0;
        if (ph == 2'd0) begin
            r.phase = 2'd1;
            ph = 2'd1;
        end
        if (s.phase == 2'd0 && (c == CH_PLUS || c == CH_MINUS)) begin
            r.neg = (c == CH_MINUS);
        end else if (is_digit(c)) begin
            if (!(ph == 2'd3 || s.ovf || (ph == 2'd2 && s.frac == 4'd15))) begin
                w = ({4'b0, s.mant} << 3) + ({4'b0, s.mant} << 1)
                    + (MANT_BITS+4)'(c - CH_ZERO);
                if (w > {4'b0, MANT_MAX}) begin
                    r.mant = MANT_MAX;
                    r.ovf  = 1'b1;
                end else begin
                    r.mant = w[MANT_BITS-1:0];
                    if (ph == 2'd2)
                        r.frac = s.frac + 4'd1;
                end
            end
        end else if (c == CH_DOT && ph == 2'd1) begin
            r.phase = 2'd2;
        end else begin
            r.phase = 2'd3;
        end
        return r;
    endfunction

    logic [7:0]          b;
    logic [POS_BITS-1:0] p, p1;
    logic                go;
    logic [4:0]          h;
    logic [4:0]          esc_h;

    // per-byte decision logic
    always_comb
    begin
        mode_next    = mode_reg;
        pos_next     = pos_reg;
        start_next   = start_reg;
        depth_next   = depth_reg;
        oct_val_next = oct_val_reg;
        oct_cnt_next = oct_cnt_reg;
        hex_nib_next = hex_nib_reg;
        esc_next     = esc_reg;
        num_next     = num_reg;
        grp          = '0;
        go           = 1'b1;
        b            = item.data_byte;
        p            = pos_reg;
        p1           = pos_reg + 1'b1;
        h            = hexval(item.data_byte);
        esc_h        = hexval(esc_reg);

        if (item.end_of_stream) begin
            // flush the open token, then the end token
            unique case (mode_reg)
                M_HASH0:
                    grp = push(grp, mk_byte(KIND_NAME, CH_HASH));
                M_HASH1:
                begin
                    grp = push(grp, mk_byte(KIND_NAME, CH_HASH));
                    grp = push(grp, mk_byte(KIND_NAME, esc_reg));
                end
                M_STR_OCT:
                    grp = push(grp, mk_byte(KIND_STRING, oct_val_reg));
                M_HEX:
                    if (hex_nib_reg[4])
                        grp = push(grp, mk_byte(KIND_STRING, {hex_nib_reg[3:0], 4'h0}));
                default: ;
            endcase
            unique case (mode_reg)
                M_OPER, M_GT:
                    grp = push(grp, mk_done(KIND_OPERATOR, 32'(start_reg), 32'(p), 1'b0,
                                            '0, '0, num_reg.ovf));
                M_NAME, M_HASH0, M_HASH1:
                    grp = push(grp, mk_done(KIND_NAME, 32'(start_reg), 32'(p), 1'b0,
                                            '0, '0, num_reg.ovf));
                M_NUM:
                    grp = push(grp, mk_done(KIND_NUMBER, 32'(start_reg), 32'(p),
                                            num_reg.neg, 48'(num_reg.mant), num_reg.frac,
                                            num_reg.ovf));
                M_LT, M_STR, M_STR_ESC, M_STR_CR, M_STR_OCT, M_HEX:
                    grp = push(grp, mk_done(KIND_STRING, 32'(start_reg), 32'(p), 1'b0,
                                            '0, '0, num_reg.ovf));
                default: ;
            endcase
            grp = push(grp, mk_done(KIND_END, 32'(p), 32'(p), 1'b0, '0, '0, 1'b0));
            mode_next    = M_IDLE;
            pos_next     = '0;
            start_next   = '0;
            depth_next   = '0;
            oct_val_next = '0;
            oct_cnt_next = '0;
            hex_nib_next = '0;
            esc_next     = '0;
            num_next     = '0;
        end else begin
            pos_next = p1;

            // escapes and lookahead modes that hand the byte on
            unique case (mode_reg)
                M_HASH0:
                    if (!h[4]) begin
                        esc_next  = b;
                        mode_next = M_HASH1;
                        go        = 1'b0;
                    end else begin
                        grp       = push(grp, mk_byte(KIND_NAME, CH_HASH));
                        mode_next = M_NAME;
                    end
                M_HASH1:
                begin
                    mode_next = M_NAME;
                    if (!h[4]) begin
                        grp = push(grp, mk_byte(KIND_NAME, {esc_h[3:0], h[3:0]}));
                        go  = 1'b0;
                    end else begin
                        grp = push(grp, mk_byte(KIND_NAME, CH_HASH));
                        grp = push(grp, mk_byte(KIND_NAME, esc_reg));
                    end
                end
                M_STR_CR:
                begin
                    mode_next = M_STR;
                    if (b == CH_LF)
                        go = 1'b0;
                end
                M_STR_OCT:
                    if (is_octal(b) && oct_cnt_reg < 2'd3) begin
                        oct_val_next = {oct_val_reg[4:0], b[2:0]};
                        oct_cnt_next = oct_cnt_reg + 2'd1;
                        if (oct_cnt_reg == 2'd2) begin
                            grp       = push(grp, mk_byte(KIND_STRING, oct_val_next));
                            mode_next = M_STR;
                        end
                        go = 1'b0;
                    end else begin
                        grp       = push(grp, mk_byte(KIND_STRING, oct_val_reg));
                        mode_next = M_STR;
                    end
                M_LT:
                    if (b == CH_LT) begin
                        grp = push(grp, mk_done(KIND_DICT_OPEN, 32'(start_reg), 32'(p1),
                                                1'b0, '0, '0, num_reg.ovf));
                        mode_next = M_IDLE;
                        go        = 1'b0;
                    end else begin
                        hex_nib_next = '0;
                        mode_next    = M_HEX;
                    end
                M_GT:
                begin
                    mode_next = M_IDLE;
                    if (b == CH_GT) begin
                        grp = push(grp, mk_done(KIND_DICT_CLOSE, 32'(start_reg), 32'(p1),
                                                1'b0, '0, '0, num_reg.ovf));
                        go  = 1'b0;
                    end else begin
                        grp = push(grp, mk_done(KIND_OPERATOR, 32'(start_reg), 32'(p),
                                                1'b0, '0, '0, num_reg.ovf));
                    end
                end
                default: ;
            endcase

            // body of the open token
            if (go) begin
                unique case (mode_next)
                    M_IDLE: ;
                    M_COMMENT:
                    begin
                        if (b == CH_LF || b == CH_CR)
                            mode_next = M_IDLE;
                        go = 1'b0;
                    end
                    M_OPER:
                        if (is_ws(b) || is_delim(b)) begin
                            grp = push(grp, mk_done(KIND_OPERATOR, 32'(start_reg), 32'(p),
                                                    1'b0, '0, '0, num_reg.ovf));
                            mode_next = M_IDLE;
                        end else begin
                            grp = push(grp, mk_byte(KIND_OPERATOR, b));
                            go  = 1'b0;
                        end
                    M_NAME:
                        if (is_ws(b) || is_delim(b)) begin
                            grp = push(grp, mk_done(KIND_NAME, 32'(start_reg), 32'(p),
                                                    1'b0, '0, '0, num_reg.ovf));
                            mode_next = M_IDLE;
                        end else begin
                            if (b == CH_HASH)
                                mode_next = M_HASH0;
                            else
                                grp = push(grp, mk_byte(KIND_NAME, b));
                            go = 1'b0;
                        end
                    M_NUM:
                        if (is_numch(b)) begin
                            num_next = num_step(num_reg, b);
                            go       = 1'b0;
                        end else begin
                            grp = push(grp, mk_done(KIND_NUMBER, 32'(start_reg), 32'(p),
                                                    num_reg.neg, 48'(num_reg.mant),
                                                    num_reg.frac, num_reg.ovf));
                            mode_next = M_IDLE;
                        end
                    M_STR:
                    begin
                        go = 1'b0;
                        if (b == CH_BSLASH) begin
                            mode_next = M_STR_ESC;
                        end else if (b == CH_LPAR) begin
                            if (depth_reg == DEPTH_MAX)
                                num_next.ovf = 1'b1;
                            else
                                depth_next = depth_reg + 1'b1;
                            grp = push(grp, mk_byte(KIND_STRING, b));
                        end else if (b == CH_RPAR && depth_reg <= DEPTH_BITS'(1)) begin
                            depth_next = '0;
                            grp = push(grp, mk_done(KIND_STRING, 32'(start_reg), 32'(p1),
                                                    1'b0, '0, '0, num_reg.ovf));
                            mode_next = M_IDLE;
                        end else begin
                            if (b == CH_RPAR)
                                depth_next = depth_reg - 1'b1;
                            grp = push(grp, mk_byte(KIND_STRING, b));
                        end
                    end
                    M_STR_ESC:
                    begin
                        go        = 1'b0;
                        mode_next = M_STR;
                        priority if (b == CH_LN)
                            grp = push(grp, mk_byte(KIND_STRING, CH_LF));
                        else if (b == CH_LR)
                            grp = push(grp, mk_byte(KIND_STRING, CH_CR));
                        else if (b == CH_LT_CH)
                            grp = push(grp, mk_byte(KIND_STRING, CH_TAB));
                        else if (b == CH_LB)
                            grp = push(grp, mk_byte(KIND_STRING, CH_BS));
                        else if (b == CH_LF_CH)
                            grp = push(grp, mk_byte(KIND_STRING, CH_FF));
                        else if (b == CH_CR)
                            mode_next = M_STR_CR;
                        else if (b == CH_LF)
                            mode_next = M_STR;
                        else if (is_octal(b)) begin
                            oct_val_next = {5'b0, b[2:0]};
                            oct_cnt_next = 2'd1;
                            mode_next    = M_STR_OCT;
                        end else
                            grp = push(grp, mk_byte(KIND_STRING, b));
                    end
                    M_HEX:
                    begin
                        go = 1'b0;
                        if (b == CH_GT) begin
                            if (hex_nib_reg[4])
                                grp = push(grp, mk_byte(KIND_STRING,
                                                        {hex_nib_reg[3:0], 4'h0}));
                            hex_nib_next = '0;
                            grp = push(grp, mk_done(KIND_STRING, 32'(start_reg), 32'(p1),
                                                    1'b0, '0, '0, num_reg.ovf));
                            mode_next = M_IDLE;
                        end else if (!h[4]) begin
                            if (hex_nib_reg[4]) begin
                                grp = push(grp, mk_byte(KIND_STRING,
                                                        {hex_nib_reg[3:0], h[3:0]}));
                                hex_nib_next = '0;
                            end else begin
                                hex_nib_next = {1'b1, h[3:0]};
                            end
                        end
                    end
                    default:
                        mode_next = M_IDLE;
                endcase
            end

            // start of a new token
            if (go && mode_next == M_IDLE && !is_ws(b)) begin
                if (b == CH_PCT) begin
                    mode_next = M_COMMENT;
                end else begin
                    start_next   = p;
                    num_next.ovf = 1'b0;
                    priority if (b == CH_LBRK)
                        grp = push(grp, mk_done(KIND_ARR_OPEN, 32'(p), 32'(p1), 1'b0,
                                                '0, '0, 1'b0));
                    else if (b == CH_RBRK)
                        grp = push(grp, mk_done(KIND_ARR_CLOSE, 32'(p), 32'(p1), 1'b0,
                                                '0, '0, 1'b0));
                    else if (b == CH_LPAR) begin
                        depth_next = DEPTH_BITS'(1);
                        mode_next  = M_STR;
                    end else if (b == CH_SLASH)
                        mode_next = M_NAME;
                    else if (b == CH_LT) begin
                        hex_nib_next = '0;
                        mode_next    = M_LT;
                    end else if (b == CH_GT)
                        mode_next = M_GT;
                    else if (is_numch(b)) begin
                        num_next  = num_step('0, b);
                        mode_next = M_NUM;
                    end else begin
                        grp = push(grp, mk_byte(KIND_OPERATOR, b));
                        if (is_delim(b))
                            grp = push(grp, mk_done(KIND_OPERATOR, 32'(p), 32'(p1), 1'b0,
                                                    '0, '0, 1'b0));
                        else
                            mode_next = M_OPER;
                    end
                end
            end
        end
    end

    // lexer state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg    <= M_IDLE;
            pos_reg     <= '0;
            start_reg   <= '0;
            depth_reg   <= '0;
            oct_val_reg <= '0;
            oct_cnt_reg <= '0;
            hex_nib_reg <= '0;
            esc_reg     <= '0;
            num_reg     <= '0;
        end else if (take) begin
            mode_reg    <= mode_next;
            pos_reg     <= pos_next;
            start_reg   <= start_next;
            depth_reg   <= depth_next;
            oct_val_reg <= oct_val_next;
            oct_cnt_reg <= oct_cnt_next;
            hex_nib_reg <= hex_nib_next;
            esc_reg     <= esc_next;
            num_reg     <= num_next;
        end
    end

    // an open string always has at least one level of nesting
    a_str_depth: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == M_STR || mode_reg == M_STR_ESC || mode_reg == M_STR_CR ||
         mode_reg == M_STR_OCT) |-> depth_reg != '0)
        else $error("string open with zero depth");

    // a pending octal escape holds one or two digits
    a_oct_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == M_STR_OCT |-> (oct_cnt_reg == 2'd1 || oct_cnt_reg == 2'd2))
        else $error("bad octal digit count");

    // end of stream restarts the lexer at offset zero
    a_eos_reset: assert property (@(posedge clk) disable iff (!rst_n)
        take && item.end_of_stream |=> mode_reg == M_IDLE && pos_reg == '0)
        else $error("lexer not restarted after end of stream");

endmodule

FILE: src/pdftok_outq.sv
// ----------------------------------------------------------------------------
// pdftok_outq
// Two-entry queue of result groups, drained one result per transaction.
// ----------------------------------------------------------------------------
module pdftok_outq
    import pdftok_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push_en,
    input  grp_t      push_grp,
    output logic      full,
    output logic      tok_valid,
    input  logic      tok_stall,
    output out_item_t tok_item
);

    grp_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic [1:0] sub_reg, sub_next;
    logic       pop, pop_last;
    grp_t       head;

    assign head      = slot_reg[rd_ptr_reg];
    assign tok_valid = count_reg != 2'd0;
    assign tok_item  = head.item[sub_reg];
    assign full      = count_reg == 2'd2;
    assign pop       = tok_valid && !tok_stall;
    assign pop_last  = pop && ({1'b0, sub_reg} == head.cnt - 3'd1);

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        sub_next    = sub_reg;
        count_next  = count_reg;
        if (pop) begin
            sub_next = sub_reg + 2'd1;
        end
        if (pop_last) begin
            sub_next    = 2'd0;
            rd_ptr_next = !rd_ptr_reg;
        end
        if (push_en) begin
            wr_ptr_next = !wr_ptr_reg;
        end
        count_next = count_reg + {1'b0, push_en} - {1'b0, pop_last};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
            sub_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            sub_reg    <= sub_next;
        end
    end

    // group storage
    always_ff @(posedge clk)
    begin
        if (push_en) begin
            slot_reg[wr_ptr_reg] <= push_grp;
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'd2)
        else $error("queue count out of range");

    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        push_en |-> !full && push_grp.cnt != 3'd0)
        else $error("push into full queue or empty group");

    a_head_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid |-> head.cnt != 3'd0 && {1'b0, sub_reg} < head.cnt)
        else $error("head group index out of range");

endmodule

FILE: src/pdf_content_tokenizer.sv
// ----------------------------------------------------------------------------
// pdf_content_tokenizer
// Content-stream lexer: bytes in, token bytes and token summaries out.
// ----------------------------------------------------------------------------
// Input channel byte_*: one stream byte per transaction, or an end-of-stream
// marker that flushes the open token, emits an End token and restarts offsets.
// Output channel tok_*: one result per transaction; decoded string, name and
// operator bytes first, then a done result with kind, offsets and number value.
// Each input byte is decided in the cycle it is accepted; its results (0 to 4)
// are registered into the output queue and drain at one per cycle unless stalled.
// Throughput: one byte per cycle while each byte yields at most one result and
// tok_stall is low; a byte with several results holds its buffer slot until they
// are all taken. Results of up to two bytes are buffered, so input is taken
// while a result waits to be taken. A stall on tok_stall holds the current
// result; byte_stall rises once both result buffers hold groups. Reset empties
// the buffers and puts the lexer idle at stream offset zero.
// ----------------------------------------------------------------------------
module pdf_content_tokenizer
    import pdftok_pkg::*;
#(
    parameter int POS_BITS   = 32,
    parameter int DEPTH_BITS = 16,
    parameter int MANT_BITS  = 48
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      byte_valid,
    output logic      byte_stall,
    input  in_item_t  byte_item,
    output logic      tok_valid,
    input  logic      tok_stall,
    output out_item_t tok_item
);

    logic take;
    logic full;
    grp_t grp;

    assign byte_stall = full;
    assign take       = byte_valid && !full;

    pdftok_lexer #(
        .POS_BITS   (POS_BITS),
        .DEPTH_BITS (DEPTH_BITS),
        .MANT_BITS  (MANT_BITS)
    ) u_lexer (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .item  (byte_item),
        .grp   (grp)
    );

    pdftok_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_en   (take && grp.cnt != 3'd0),
        .push_grp  (grp),
        .full      (full),
        .tok_valid (tok_valid),
        .tok_stall (tok_stall),
        .tok_item  (tok_item)
    );

endmodule

FILE: sim/tb_pdf_content_tokenizer.sv
// ----------------------------------------------------------------------------
// tb_pdf_content_tokenizer
// Self-checking bench for the content-stream tokenizer. A local lexer model
// predicts the token results of every accepted byte; a monitor compares each
// result against the oldest prediction. Stimulus is a directed token mix
// followed by random well-formed tokens, broken tokens and noise bytes, with
// random idling on both channels.
// ----------------------------------------------------------------------------
module tb_pdf_content_tokenizer
    import pdftok_pkg::*;
;

    localparam int    LIMIT_CYCLES = 300000;
    localparam int    LONG_HOLD    = 400;
    localparam logic [47:0] MANT_TOP = 48'hFFFF_FFFF_FFFF;
    localparam logic [15:0] DEPTH_TOP = 16'hFFFF;

    logic      clk;
    logic      rst_n;
    logic      byte_valid;
    logic      byte_stall;
    in_item_t  byte_item;
    logic      tok_valid;
    logic      tok_stall;
    out_item_t tok_item;

    pdf_content_tokenizer i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_item  (byte_item),
        .tok_valid  (tok_valid),
        .tok_stall  (tok_stall),
        .tok_item   (tok_item)
    );

    // stimulus and prediction stores
    in_item_t  byte_q[$];
    bit        wait_drain_q[$];
    out_item_t token_q[$];

    int errors;
    int bytes_sent;
    int tokens_seen;
    int cycles;
    bit long_hold_done;

    // lexer model state
    mode_t       lx_mode;
    logic [31:0] lx_pos;
    logic [31:0] lx_start;
    logic [15:0] lx_depth;
    logic [7:0]  lx_oct;
    logic [1:0]  lx_oct_cnt;
    logic [4:0]  lx_hex_hi;
    logic [7:0]  lx_esc;
    logic [47:0] lx_mant;
    logic [2:0]  lx_phase;
    logic [3:0]  lx_frac;
    logic        lx_neg;
    logic        lx_ovf;
    int          lx_count;

    always #4 clk = ~clk;

    function automatic void lexer_clear();
        lx_mode = M_IDLE;
        lx_pos = '0;
        lx_start = '0;
        lx_depth = '0;
        lx_oct = '0;
        lx_oct_cnt = '0;
        lx_hex_hi = '0;
        lx_esc = '0;
        lx_mant = '0;
        lx_phase = '0;
        lx_frac = '0;
        lx_neg = 1'b0;
        lx_ovf = 1'b0;
    endfunction

    function automatic bit blank(logic [7:0] c);
        return c == CH_NUL || c == CH_TAB || c == CH_LF || c == CH_FF ||
               c == CH_CR || c == CH_SPACE;
    endfunction

    function automatic bit separator(logic [7:0] c);
        return c == CH_LPAR || c == CH_RPAR || c == CH_LT || c == CH_GT ||
               c == CH_LBRK || c == CH_RBRK || c == CH_LBRC || c == CH_RBRC ||
               c == CH_SLASH || c == CH_PCT;
    endfunction

    function automatic bit numeric(logic [7:0] c);
        return (c >= CH_ZERO && c <= CH_NINE) || c == CH_PLUS || c == CH_MINUS ||
               c == CH_DOT;
    endfunction

    function automatic logic [4:0] nibble(logic [7:0] c);
        if (c >= "0" && c <= "9") return 5'(c - "0");
        if (c >= "a" && c <= "f") return 5'(c - "a" + 10);
        if (c >= "A" && c <= "F") return 5'(c - "A" + 10);
        return 5'h10;
    endfunction

    function automatic void push_token(out_item_t t);
        if (lx_count < 4)
        begin
            token_q = {token_q, t};
            lx_count++;
        end
    endfunction

    function automatic void push_byte(logic [3:0] kind, logic [7:0] b);
        out_item_t t;
        t = '0;
        t.token_kind = kind;
        t.has_byte = 1'b1;
        t.payload_byte = b;
        push_token(t);
    endfunction

    function automatic void push_done(logic [3:0] kind, logic [31:0] beg, logic [31:0] fin);
        out_item_t t;
        t = '0;
        t.token_kind = kind;
        t.token_done = 1'b1;
        t.begin_offset = beg;
        t.end_offset = fin;
        t.overflow_flag = lx_ovf;
        if (kind == KIND_NUMBER)
        begin
            t.number_negative = lx_neg;
            t.number_mantissa = lx_mant;
            t.fraction_digits = lx_frac;
        end
        push_token(t);
    endfunction

    // accumulate one number character
    function automatic void number_char(logic [7:0] c);
        logic [1:0] ph;
        longint unsigned d;
        ph = lx_phase[1:0];
        if (ph == 0)
        begin
            lx_phase = 3'd1;
            ph = 2'd1;
            if (c == CH_PLUS || c == CH_MINUS)
            begin
                lx_neg = (c == CH_MINUS);
                return;
            end
        end
        if (c >= CH_ZERO && c <= CH_NINE)
        begin
            d = c - CH_ZERO;
            if (ph == 3 || lx_ovf) return;
            if (ph == 2 && lx_frac >= 15) return;
            if (longint'(lx_mant) > (longint'(MANT_TOP) - d) / 10)
            begin
                lx_mant = MANT_TOP;
                lx_ovf = 1'b1;
                return;
            end
            lx_mant = 48'(longint'(lx_mant) * 10 + d);
            if (ph == 2) lx_frac++;
        end
        else if (c == CH_DOT && ph == 1)
            lx_phase = 3'd2;
        else
            lx_phase = 3'd3;
    endfunction

    function automatic void open_token(logic [7:0] b);
        if (blank(b)) return;
        if (b == CH_PCT)
        begin
            lx_mode = M_COMMENT;
            return;
        end
        lx_start = lx_pos;
        lx_ovf = 1'b0;
        if (b == CH_LBRK) push_done(KIND_ARR_OPEN, lx_pos, lx_pos + 1);
        else if (b == CH_RBRK) push_done(KIND_ARR_CLOSE, lx_pos, lx_pos + 1);
        else if (b == CH_LPAR)
        begin
            lx_depth = 16'd1;
            lx_mode = M_STR;
        end
        else if (b == CH_SLASH) lx_mode = M_NAME;
        else if (b == CH_LT)
        begin
            lx_hex_hi = '0;
            lx_mode = M_LT;
        end
        else if (b == CH_GT) lx_mode = M_GT;
        else if (numeric(b))
        begin
            lx_mant = '0;
            lx_frac = '0;
            lx_neg = 1'b0;
            lx_phase = '0;
            lx_mode = M_NUM;
            number_char(b);
        end
        else
        begin
            push_byte(KIND_OPERATOR, b);
            if (separator(b)) push_done(KIND_OPERATOR, lx_pos, lx_pos + 1);
            else lx_mode = M_OPER;
        end
    endfunction

    // one stream byte through the lexer, re-dispatching where a byte ends a token
    function automatic void lex_byte(logic [7:0] b);
        bit again;
        logic [4:0] h;
        logic [4:0] e;
        again = 1'b1;
        while (again)
        begin
            again = 1'b0;
            case (lx_mode)
                M_IDLE: open_token(b);
                M_COMMENT: if (b == CH_LF || b == CH_CR) lx_mode = M_IDLE;
                M_OPER:
                    if (blank(b) || separator(b))
                    begin
                        push_done(KIND_OPERATOR, lx_start, lx_pos);
                        lx_mode = M_IDLE;
                        again = 1'b1;
                    end
                    else push_byte(KIND_OPERATOR, b);
                M_NAME:
                    if (blank(b) || separator(b))
                    begin
                        push_done(KIND_NAME, lx_start, lx_pos);
                        lx_mode = M_IDLE;
                        again = 1'b1;
                    end
                    else if (b == CH_HASH) lx_mode = M_HASH0;
                    else push_byte(KIND_NAME, b);
                M_HASH0:
                begin
                    h = nibble(b);
                    if (!h[4])
                    begin
                        lx_esc = b;
                        lx_mode = M_HASH1;
                    end
                    else
                    begin
                        push_byte(KIND_NAME, CH_HASH);
                        lx_mode = M_NAME;
                        again = 1'b1;
                    end
                end
                M_HASH1:
                begin
                    h = nibble(b);
                    e = nibble(lx_esc);
                    lx_mode = M_NAME;
                    if (!h[4]) push_byte(KIND_NAME, {e[3:0], h[3:0]});
                    else
                    begin
                        push_byte(KIND_NAME, CH_HASH);
                        push_byte(KIND_NAME, lx_esc);
                        again = 1'b1;
                    end
                end
                M_NUM:
                    if (numeric(b)) number_char(b);
                    else
                    begin
                        push_done(KIND_NUMBER, lx_start, lx_pos);
                        lx_mode = M_IDLE;
                        again = 1'b1;
                    end
                M_LT:
                    if (b == CH_LT)
                    begin
                        push_done(KIND_DICT_OPEN, lx_start, lx_pos + 1);
                        lx_mode = M_IDLE;
                    end
                    else
                    begin
                        lx_hex_hi = '0;
                        lx_mode = M_HEX;
                        again = 1'b1;
                    end
                M_GT:
                    if (b == CH_GT)
                    begin
                        push_done(KIND_DICT_CLOSE, lx_start, lx_pos + 1);
                        lx_mode = M_IDLE;
                    end
                    else
                    begin
                        push_done(KIND_OPERATOR, lx_start, lx_pos);
                        lx_mode = M_IDLE;
                        again = 1'b1;
                    end
                M_STR:
                    if (b == CH_BSLASH) lx_mode = M_STR_ESC;
                    else if (b == CH_LPAR)
                    begin
                        if (lx_depth >= DEPTH_TOP) lx_ovf = 1'b1;
                        else lx_depth++;
                        push_byte(KIND_STRING, b);
                    end
                    else if (b == CH_RPAR && lx_depth <= 1)
                    begin
                        lx_depth = '0;
                        push_done(KIND_STRING, lx_start, lx_pos + 1);
                        lx_mode = M_IDLE;
                    end
                    else
                    begin
                        if (b == CH_RPAR) lx_depth--;
                        push_byte(KIND_STRING, b);
                    end
                M_STR_ESC:
                begin
                    lx_mode = M_STR;
                    if (b == CH_LN) push_byte(KIND_STRING, CH_LF);
                    else if (b == CH_LR) push_byte(KIND_STRING, CH_CR);
                    else if (b == CH_LT_CH) push_byte(KIND_STRING, CH_TAB);
                    else if (b == CH_LB) push_byte(KIND_STRING, CH_BS);
                    else if (b == CH_LF_CH) push_byte(KIND_STRING, CH_FF);
                    else if (b == CH_CR) lx_mode = M_STR_CR;
                    else if (b == CH_LF) ;
                    else if (b >= CH_ZERO && b <= CH_SEVEN)
                    begin
                        lx_oct = b - CH_ZERO;
                        lx_oct_cnt = 2'd1;
                        lx_mode = M_STR_OCT;
                    end
                    else push_byte(KIND_STRING, b);
                end
                M_STR_CR:
                begin
                    lx_mode = M_STR;
                    if (b != CH_LF) again = 1'b1;
                end
                M_STR_OCT:
                    if (b >= CH_ZERO && b <= CH_SEVEN && lx_oct_cnt < 3)
                    begin
                        lx_oct = {lx_oct[4:0], 3'(b - CH_ZERO)};
                        lx_oct_cnt++;
                        if (lx_oct_cnt >= 3)
                        begin
                            push_byte(KIND_STRING, lx_oct);
                            lx_mode = M_STR;
                        end
                    end
                    else
                    begin
                        push_byte(KIND_STRING, lx_oct);
                        lx_mode = M_STR;
                        again = 1'b1;
                    end
                M_HEX:
                    if (b == CH_GT)
                    begin
                        if (lx_hex_hi[4]) push_byte(KIND_STRING, {lx_hex_hi[3:0], 4'h0});
                        lx_hex_hi = '0;
                        push_done(KIND_STRING, lx_start, lx_pos + 1);
                        lx_mode = M_IDLE;
                    end
                    else
                    begin
                        h = nibble(b);
                        if (!h[4])
                        begin
                            if (lx_hex_hi[4])
                            begin
                                push_byte(KIND_STRING, {lx_hex_hi[3:0], h[3:0]});
                                lx_hex_hi = '0;
                            end
                            else lx_hex_hi = {1'b1, h[3:0]};
                        end
                    end
                default:
                begin
                    lx_mode = M_IDLE;
                    again = 1'b1;
                end
            endcase
        end
    endfunction

    // close whatever token is open and emit the end token
    function automatic void lex_flush();
        case (lx_mode)
            M_OPER, M_GT: push_done(KIND_OPERATOR, lx_start, lx_pos);
            M_NAME: push_done(KIND_NAME, lx_start, lx_pos);
            M_HASH0:
            begin
                push_byte(KIND_NAME, CH_HASH);
                push_done(KIND_NAME, lx_start, lx_pos);
            end
            M_HASH1:
            begin
                push_byte(KIND_NAME, CH_HASH);
                push_byte(KIND_NAME, lx_esc);
                push_done(KIND_NAME, lx_start, lx_pos);
            end
            M_NUM: push_done(KIND_NUMBER, lx_start, lx_pos);
            M_LT, M_STR, M_STR_ESC, M_STR_CR: push_done(KIND_STRING, lx_start, lx_pos);
            M_STR_OCT:
            begin
                push_byte(KIND_STRING, lx_oct);
                push_done(KIND_STRING, lx_start, lx_pos);
            end
            M_HEX:
            begin
                if (lx_hex_hi[4]) push_byte(KIND_STRING, {lx_hex_hi[3:0], 4'h0});
                push_done(KIND_STRING, lx_start, lx_pos);
            end
            default: ;
        endcase
        lx_ovf = 1'b0;
        push_done(KIND_END, lx_pos, lx_pos);
        lexer_clear();
    endfunction

    function automatic void predict_tokens(in_item_t it);
        lx_count = 0;
        if (it.end_of_stream) lex_flush();
        else
        begin
            lex_byte(it.data_byte);
            lx_pos = lx_pos + 1;
        end
    endfunction

    // stimulus helpers
    function automatic void put_byte(logic [7:0] b, bit drain = 1'b0);
        in_item_t it;
        it.data_byte = b;
        it.end_of_stream = 1'b0;
        byte_q = {byte_q, it};
        wait_drain_q = {wait_drain_q, drain};
    endfunction

    function automatic void put_text(string s);
        for (int i = 0; i < s.len(); i++) put_byte(s[i]);
    endfunction

    function automatic void put_end();
        in_item_t it;
        it.data_byte = 8'($urandom_range(0, 255));
        it.end_of_stream = 1'b1;
        byte_q = {byte_q, it};
        wait_drain_q = {wait_drain_q, 1'b0};
    endfunction

    function automatic byte rand_hex();
        string hx;
        hx = "0123456789abcdefABCDEF";
        return hx[$urandom_range(0, 21)];
    endfunction

    function automatic void put_digits(int n);
        for (int i = 0; i < n; i++) put_byte(8'("0" + $urandom_range(0, 9)));
    endfunction

    // one random token, mostly well formed
    function automatic void put_random_token();
        logic [7:0] blanks [6];
        string picks;
        int n;
        blanks = '{CH_NUL, CH_TAB, CH_LF, CH_FF, CH_CR, CH_SPACE};
        case ($urandom_range(0, 13))
            0, 1:
            begin
                if ($urandom_range(0, 2) == 0) put_byte($urandom_range(0, 1) ? "-" : "+");
                put_digits($urandom_range(0, 4) == 0 ? $urandom_range(14, 20)
                                                     : $urandom_range(0, 5));
                if ($urandom_range(0, 1))
                begin
                    put_byte(".");
                    put_digits($urandom_range(0, 4) == 0 ? 18 : $urandom_range(0, 4));
                end
                if ($urandom_range(0, 7) == 0) put_text("-.5");
            end
            2, 3:
            begin
                put_byte("/");
                n = $urandom_range(0, 5);
                for (int i = 0; i < n; i++)
                begin
                    if ($urandom_range(0, 3) == 0)
                    begin
                        put_byte("#");
                        if ($urandom_range(0, 3) != 0) put_byte(rand_hex());
                        if ($urandom_range(0, 3) != 0) put_byte(rand_hex());
                    end
                    else put_byte(8'("a" + $urandom_range(0, 25)));
                end
            end
            4, 5:
            begin
                put_byte("(");
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++)
                    case ($urandom_range(0, 6))
                        0: put_text("(x)");
                        1:
                        begin
                            picks = "nrtbf()\\z";
                            put_byte("\\");
                            put_byte(picks[$urandom_range(0, 8)]);
                        end
                        2:
                        begin
                            put_byte("\\");
                            for (int k = $urandom_range(1, 4); k > 0; k--)
                                put_byte(8'("0" + $urandom_range(0, 7)));
                        end
                        3:
                        begin
                            put_byte("\\");
                            put_byte(CH_CR);
                            if ($urandom_range(0, 1)) put_byte(CH_LF);
                        end
                        4: put_text("\\\n");
                        default: put_byte(8'($urandom_range(32, 126)));
                    endcase
                if ($urandom_range(0, 7) != 0) put_byte(")");
            end
            6:
            begin
                put_byte("<");
                n = $urandom_range(0, 7);
                for (int i = 0; i < n; i++)
                    put_byte($urandom_range(0, 4) == 0 ? " " : rand_hex());
                put_byte(">");
            end
            7: put_byte($urandom_range(0, 1) ? CH_LBRK : CH_RBRK);
            8: put_text($urandom_range(0, 1) ? "<<" : ">>");
            9:
            begin
                picks = "TjmBfqQcS*'";
                n = $urandom_range(1, 3);
                for (int i = 0; i < n; i++) put_byte(picks[$urandom_range(0, 10)]);
            end
            10:
            begin
                put_text("% note");
                put_byte($urandom_range(0, 1) ? CH_LF : CH_CR);
            end
            11:
            begin
                picks = ")}{>";
                put_byte(picks[$urandom_range(0, 3)]);
            end
            12: put_end();
            default: put_byte(8'($urandom_range(0, 255)));
        endcase
        put_byte(blanks[$urandom_range(0, 5)]);
    endfunction

    function automatic void compare_token(out_item_t got, out_item_t want);
        if (got.token_kind != want.token_kind)
            $error("token_kind expected %0d actual %0d", want.token_kind, got.token_kind);
        if (got.has_byte != want.has_byte)
            $error("has_byte expected %0d actual %0d", want.has_byte, got.has_byte);
        if (got.payload_byte != want.payload_byte)
            $error("payload_byte expected %h actual %h", want.payload_byte, got.payload_byte);
        if (got.token_done != want.token_done)
            $error("token_done expected %0d actual %0d", want.token_done, got.token_done);
        if (got.begin_offset != want.begin_offset)
            $error("begin_offset expected %0d actual %0d", want.begin_offset,
                   got.begin_offset);
        if (got.end_offset != want.end_offset)
            $error("end_offset expected %0d actual %0d", want.end_offset, got.end_offset);
        if (got.number_negative != want.number_negative)
            $error("number_negative expected %0d actual %0d", want.number_negative,
                   got.number_negative);
        if (got.number_mantissa != want.number_mantissa)
            $error("number_mantissa expected %0d actual %0d", want.number_mantissa,
                   got.number_mantissa);
        if (got.fraction_digits != want.fraction_digits)
            $error("fraction_digits expected %0d actual %0d", want.fraction_digits,
                   got.fraction_digits);
        if (got.overflow_flag != want.overflow_flag)
            $error("overflow_flag expected %0d actual %0d", want.overflow_flag,
                   got.overflow_flag);
        if (got != want) errors++;
    endfunction

    // byte driver: random gaps, bursts without gaps, optional drain pause
    int  gap_left;
    bit  burst;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid <= 1'b0;
            byte_item <= '0;
            gap_left <= 0;
            burst <= 1'b0;
        end
        else if (!byte_valid || !byte_stall)
        begin
            if (byte_valid)
            begin
                predict_tokens(byte_item);
                bytes_sent++;
            end
            if (gap_left > 0)
            begin
                byte_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (byte_q.size() > 0 && !(wait_drain_q[0] && token_q.size() > 0))
            begin
                byte_item <= byte_q.pop_front();
                void'(wait_drain_q.pop_front());
                byte_valid <= 1'b1;
                if ($urandom_range(0, 49) == 0) burst <= ~burst;
                gap_left <= burst ? 0 : $urandom_range(0, 19);
            end
            else byte_valid <= 1'b0;
        end
    end

    // token monitor: random stalls, one long hold to back up the input
    int hold_left;
    always @(posedge clk or negedge rst_n)
    begin
        int nh;
        if (!rst_n)
        begin
            tok_stall <= 1'b0;
            hold_left <= 0;
        end
        else
        begin
            nh = hold_left;
            if (tok_valid && !tok_stall)
            begin
                tokens_seen++;
                if (token_q.size() == 0)
                begin
                    $error("unexpected token result kind %0d", tok_item.token_kind);
                    errors++;
                end
                else compare_token(tok_item, token_q.pop_front());
                nh = burst ? 0 : $urandom_range(0, 19);
                if (tokens_seen == 60 && !long_hold_done)
                begin
                    nh = LONG_HOLD;
                    long_hold_done = 1'b1;
                end
            end
            tok_stall <= (nh > 0);
            hold_left <= (nh > 0) ? nh - 1 : 0;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        errors = 0;
        bytes_sent = 0;
        tokens_seen = 0;
        cycles = 0;
        long_hold_done = 1'b0;
        lexer_clear();

        // directed: brackets, dict marks, escaped name, octal, odd hex, number,
        // operator, comment, stray delimiters, high byte, end inside a string
        put_text("[]<</A#41>>(a\\101)<4f4>-12.5 BT%c\n>){");
        put_byte(8'hFF);
        put_text(" (z\\7");
        put_end();
        // wait for the block to drain before more stimulus
        put_byte(" ", 1'b1);
        put_text("1234567890123456 0.12345678901234567 /x#4");
        put_end();
        while (byte_q.size() < 180) put_random_token();
        put_end();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        wait (byte_q.size() == 0 && !byte_valid);
        wait (token_q.size() == 0);
        repeat (10) @(posedge clk);

        $display("sent %0d stream bytes, checked %0d token results", bytes_sent,
                 tokens_seen);
        if (errors == 0 && token_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

FILE: files.f
src/pdftok_pkg.sv
src/pdftok_lexer.sv
src/pdftok_outq.sv
src/pdf_content_tokenizer.sv
sim/tb_pdf_content_tokenizer.sv
